/* rtl/core/scsa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsa_pkg
// Shared types, constants and helpers of the size-class slab allocator.
// ----------------------------------------------------------------------------
package scsa_pkg;

    localparam int BLOCK_BYTES  = 4096;
    localparam int NUM_BLOCKS   = 1024;
    localparam int MAX_CHUNK    = 256;
    localparam int SIZE_STEP    = 8;
    localparam int HEADER_BYTES = 56;

    localparam int BLK_W       = $clog2(NUM_BLOCKS);
    localparam int BID_W       = BLK_W + 1;
    localparam int OFF_W       = $clog2(BLOCK_BYTES);
    localparam int STEP_W      = $clog2(SIZE_STEP);
    localparam int NUM_CLASSES = (MAX_CHUNK + SIZE_STEP - 1) / SIZE_STEP + 1;
    localparam int CLS_W       = $clog2(NUM_CLASSES);
    localparam int SZ_W        = CLS_W + STEP_W;
    localparam int USED_W      = 9;
    localparam int LINK_AW     = BLK_W + OFF_W - STEP_W;
    localparam int LINK_DEPTH  = 2 ** LINK_AW;
    localparam int ADDR_W      = 22;

    localparam logic [BID_W-1:0] NONE_BLK = BID_W'(NUM_BLOCKS);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_BLOCK = 2'd1;
    localparam logic [1:0] ST_BAD_SIZE = 2'd2;
    localparam logic [1:0] ST_BAD_ADDR = 2'd3;

    localparam logic REG_BLOCKS_AVAIL = 1'b0;

    typedef struct packed {
        logic              listed;
        logic [USED_W-1:0] used;
        logic [OFF_W-1:0]  fhead;
        logic [OFF_W-1:0]  uninit;
        logic [BID_W-1:0]  prv;
        logic [BID_W-1:0]  nxt;
        logic [CLS_W-1:0]  cls;
    } hdr_t;

    localparam int HDR_W = $bits(hdr_t);

    typedef enum logic [4:0] {
        S_IDLE,
        S_CH_RD,
        S_HDR,
        S_SPARE,
        S_NEWBLK,
        S_SERVE,
        S_LINK,
        U_START,
        U_HEAD,
        U_PN,
        U_NP,
        S_TOSPARE,
        F_HDR,
        F_WB,
        F_PUSH,
        F_PUSH2
    } state_t;

    typedef enum logic [1:0] {
        RET_ALLOC_OK,
        RET_ALLOC_FAIL,
        RET_FREE_SPARE
    } ret_t;

    function automatic logic blk_ok(input logic [BID_W-1:0] b);
        return b < NONE_BLK;
    endfunction

endpackage

/* rtl/core/scsa_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsa_ram
// Simple dual-port synchronous RAM with bit write mask and registered read.
// ----------------------------------------------------------------------------
module scsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [WIDTH-1:0] wmask,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            for (int i = 0; i < WIDTH; i++)
            begin
                if (wmask[i])
                begin
                    mem[waddr][i] <= wdata[i];
                end
            end
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/size_class_slab_allocator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_slab_allocator_unit
// Slab allocator with 33 size-class block lists kept in on-chip memories.
// ----------------------------------------------------------------------------
// A rejected transaction answers in the cycle after it is taken.
// One transaction is in flight at a time; the sequencer issues one dependent
// read of the class-head, header or chunk-link memory per cycle.
// Reset clears the class-head valid bits, the spare list and the bump count
// at once; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module size_class_slab_allocator_unit
    import scsa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                func,
    input  logic [15:0]         request_size,
    input  logic [31:0]         free_address,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [ADDR_W-1:0]   chunk_address,
    output logic [1:0]          status
);

    state_t                state_reg, state_next;
    ret_t                  ret_reg, ret_next;
    logic [BLK_W-1:0]      blk_reg, blk_next;
    logic [OFF_W-1:0]      off_reg, off_next;
    logic [CLS_W-1:0]      cls_reg, cls_next;
    hdr_t                  hdr_reg, hdr_next;
    logic [BID_W-1:0]      nb_reg, nb_next;
    logic [BID_W-1:0]      pb_reg, pb_next;
    logic [BID_W-1:0]      spare_reg, spare_next;
    logic [BID_W-1:0]      bump_reg, bump_next;
    logic [BID_W-1:0]      blocks_avail_reg;
    logic [NUM_CLASSES-1:0] ch_valid_reg, ch_valid_next;
    logic                  head_vld_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]     chunk_address_reg, chunk_address_next;
    logic [1:0]            status_reg, status_next;

    logic                  hdr_we;
    logic [BLK_W-1:0]      hdr_waddr, hdr_raddr;
    hdr_t                  hdr_wdata, hdr_wmask, hdr_q, hdr_mod;
    logic                  ch_we;
    logic [CLS_W-1:0]      ch_waddr, ch_raddr;
    logic [BID_W-1:0]      ch_wdata, ch_rdata;
    logic                  lk_we;
    logic [LINK_AW-1:0]    lk_waddr, lk_raddr;
    logic [OFF_W-1:0]      lk_wdata, lk_rdata;

    logic                  acc;
    logic                  cfg_wr;
    logic [SZ_W-1:0]       cls_sum;
    logic [CLS_W-1:0]      cls_in;
    logic                  size_bad;
    logic [BLK_W-1:0]      free_b;
    logic [OFF_W-1:0]      free_off;
    logic                  free_bad;
    logic [BID_W-1:0]      limit;
    logic [BID_W-1:0]      head_eff;
    logic                  head_ok, spare_ok, bump_ok;
    logic [SZ_W-1:0]       sz;
    logic [OFF_W:0]        nu;
    logic [OFF_W+1:0]      nu_chk;
    logic [OFF_W-1:0]      new_uninit;
    logic                  uninit_ok;
    logic                  srv_fail, srv_link, srv_unlink;
    logic                  lk_empty;
    logic [USED_W-1:0]     used_dec;

    scsa_ram #(
        .WIDTH (HDR_W),
        .DEPTH (NUM_BLOCKS)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (hdr_we),
        .waddr (hdr_waddr),
        .wdata (hdr_wdata),
        .wmask (hdr_wmask),
        .raddr (hdr_raddr),
        .rdata (hdr_q)
    );

    scsa_ram #(
        .WIDTH (BID_W),
        .DEPTH (NUM_CLASSES)
    ) u_head_ram (
        .clk   (clk),
        .we    (ch_we),
        .waddr (ch_waddr),
        .wdata (ch_wdata),
        .wmask ({BID_W{1'b1}}),
        .raddr (ch_raddr),
        .rdata (ch_rdata)
    );

    scsa_ram #(
        .WIDTH (OFF_W),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (lk_we),
        .waddr (lk_waddr),
        .wdata (lk_wdata),
        .wmask ({OFF_W{1'b1}}),
        .raddr (lk_raddr),
        .rdata (lk_rdata)
    );

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_BLOCKS_AVAIL);
    assign prdata   = (paddr[2] == REG_BLOCKS_AVAIL) ? 32'(blocks_avail_reg) : 32'd0;

    assign in_stall      = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign acc           = in_valid && !in_stall;
    assign out_valid     = out_valid_reg;
    assign chunk_address = chunk_address_reg;
    assign status        = status_reg;

    assign cls_sum  = SZ_W'(request_size[SZ_W-1:0]) + SZ_W'(SIZE_STEP - 1);
    assign cls_in   = CLS_W'(cls_sum >> STEP_W);
    assign size_bad = (request_size == 16'd0) || (request_size > 16'(MAX_CHUNK));
    assign free_b   = free_address[OFF_W +: BLK_W];
    assign free_off = free_address[OFF_W-1:0];
    assign free_bad = ((free_address >> (BLK_W + OFF_W)) != 32'd0)
                   || ({1'b0, free_b} >= bump_reg)
                   || (free_off < OFF_W'(HEADER_BYTES));
    assign limit    = (blocks_avail_reg < NONE_BLK) ? blocks_avail_reg : NONE_BLK;

    assign head_eff = head_vld_reg ? ch_rdata : NONE_BLK;
    assign head_ok  = blk_ok(head_eff);
    assign spare_ok = blk_ok(spare_reg);
    assign bump_ok  = bump_reg < limit;

    assign sz         = SZ_W'(hdr_reg.cls) << STEP_W;
    assign uninit_ok  = hdr_reg.uninit != '0;
    assign nu         = {1'b0, hdr_reg.uninit} + (OFF_W+1)'(sz);
    assign nu_chk     = {1'b0, nu} + (OFF_W+2)'(sz);
    assign new_uninit = (nu_chk > (OFF_W+2)'(BLOCK_BYTES)) ? '0 : nu[OFF_W-1:0];
    assign srv_fail   = !uninit_ok && (hdr_reg.fhead == '0);
    assign srv_link   = !uninit_ok && (hdr_reg.fhead != '0);
    assign srv_unlink = uninit_ok && (new_uninit == '0) && (hdr_reg.fhead == '0);
    assign lk_empty   = lk_rdata == '0;
    assign used_dec   = (hdr_q.used == '0) ? '0 : hdr_q.used - USED_W'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (!func)
                    begin
                        state_next = size_bad ? S_IDLE : S_CH_RD;
                    end
                    else
                    begin
                        state_next = free_bad ? S_IDLE : F_HDR;
                    end
                end
            end
            S_CH_RD:
            begin
                if (head_ok)
                begin
                    state_next = S_HDR;
                end
                else if (spare_ok)
                begin
                    state_next = S_SPARE;
                end
                else if (bump_ok)
                begin
                    state_next = S_NEWBLK;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_HDR:     state_next = S_SERVE;
            S_SPARE:   state_next = S_NEWBLK;
            S_NEWBLK:  state_next = S_SERVE;
            S_SERVE:
            begin
                if (srv_fail || srv_unlink)
                begin
                    state_next = U_START;
                end
                else if (srv_link)
                begin
                    state_next = S_LINK;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_LINK:    state_next = lk_empty ? U_START : S_IDLE;
            U_START:   state_next = U_HEAD;
            U_HEAD:    state_next = U_PN;
            U_PN:      state_next = U_NP;
            U_NP:      state_next = (ret_reg == RET_FREE_SPARE) ? S_TOSPARE : S_IDLE;
            S_TOSPARE: state_next = S_IDLE;
            F_HDR:
            begin
                if (!hdr_q.listed)
                begin
                    state_next = F_PUSH;
                end
                else if (used_dec == '0)
                begin
                    state_next = U_START;
                end
                else
                begin
                    state_next = F_WB;
                end
            end
            F_WB:      state_next = S_IDLE;
            F_PUSH:    state_next = head_ok ? F_PUSH2 : S_IDLE;
            F_PUSH2:   state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ret_next           = ret_reg;
        blk_next           = blk_reg;
        off_next           = off_reg;
        cls_next           = cls_reg;
        hdr_next           = hdr_reg;
        nb_next            = nb_reg;
        pb_next            = pb_reg;
        spare_next         = spare_reg;
        bump_next          = bump_reg;
        ch_valid_next      = ch_valid_reg;
        out_valid_next     = out_valid_reg && out_stall;
        chunk_address_next = chunk_address_reg;
        status_next        = status_reg;
        hdr_mod            = hdr_reg;
        hdr_we             = 1'b0;
        hdr_waddr          = blk_reg;
        hdr_wdata          = hdr_reg;
        hdr_wmask          = '1;
        hdr_raddr          = blk_reg;
        ch_we              = 1'b0;
        ch_waddr           = hdr_reg.cls;
        ch_wdata           = {1'b0, blk_reg};
        ch_raddr           = hdr_reg.cls;
        lk_we              = 1'b0;
        lk_waddr           = {blk_reg, off_reg[OFF_W-1:STEP_W]};
        lk_wdata           = hdr_reg.fhead;
        lk_raddr           = {blk_reg, hdr_reg.fhead[OFF_W-1:STEP_W]};

        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (!func)
                    begin
                        cls_next = cls_in;
                        ch_raddr = cls_in;
                        if (size_bad)
                        begin
                            out_valid_next     = 1'b1;
                            chunk_address_next = '0;
                            status_next        = ST_BAD_SIZE;
                        end
                    end
                    else
                    begin
                        blk_next  = free_b;
                        off_next  = free_off;
                        hdr_raddr = free_b;
                        if (free_bad)
                        begin
                            out_valid_next     = 1'b1;
                            chunk_address_next = '0;
                            status_next        = ST_BAD_ADDR;
                        end
                    end
                end
            end
            S_CH_RD:
            begin
                if (head_ok)
                begin
                    blk_next  = head_eff[BLK_W-1:0];
                    hdr_raddr = head_eff[BLK_W-1:0];
                end
                else if (spare_ok)
                begin
                    blk_next  = spare_reg[BLK_W-1:0];
                    hdr_raddr = spare_reg[BLK_W-1:0];
                end
                else if (bump_ok)
                begin
                    blk_next  = bump_reg[BLK_W-1:0];
                    bump_next = bump_reg + BID_W'(1);
                end
                else
                begin
                    out_valid_next     = 1'b1;
                    chunk_address_next = '0;
                    status_next        = ST_NO_BLOCK;
                end
            end
            S_HDR:
            begin
                hdr_next = hdr_q;
            end
            S_SPARE:
            begin
                spare_next = blk_ok(hdr_q.nxt) ? hdr_q.nxt : NONE_BLK;
            end
            S_NEWBLK:
            begin
                ch_we                   = 1'b1;
                ch_waddr                = cls_reg;
                ch_valid_next[cls_reg]  = 1'b1;
                hdr_next.cls            = cls_reg;
                hdr_next.nxt            = NONE_BLK;
                hdr_next.prv            = NONE_BLK;
                hdr_next.uninit         = OFF_W'(HEADER_BYTES);
                hdr_next.fhead          = '0;
                hdr_next.used           = '0;
                hdr_next.listed         = 1'b1;
            end
            S_SERVE:
            begin
                nb_next = hdr_reg.nxt;
                pb_next = hdr_reg.prv;
                if (uninit_ok)
                begin
                    off_next       = hdr_reg.uninit;
                    hdr_mod.uninit = new_uninit;
                    hdr_mod.used   = hdr_reg.used + USED_W'(1);
                    hdr_next       = hdr_mod;
                    ret_next       = RET_ALLOC_OK;
                    if (!srv_unlink)
                    begin
                        hdr_we             = 1'b1;
                        hdr_wdata          = hdr_mod;
                        out_valid_next     = 1'b1;
                        chunk_address_next = {blk_reg, hdr_reg.uninit};
                        status_next        = ST_OK;
                    end
                end
                else if (srv_fail)
                begin
                    hdr_next.uninit = '0;
                    ret_next        = RET_ALLOC_FAIL;
                end
                else
                begin
                    off_next        = hdr_reg.fhead;
                    hdr_next.uninit = '0;
                end
            end
            S_LINK:
            begin
                hdr_mod.fhead = lk_rdata;
                hdr_mod.used  = hdr_reg.used + USED_W'(1);
                hdr_next      = hdr_mod;
                ret_next      = RET_ALLOC_OK;
                if (!lk_empty)
                begin
                    hdr_we             = 1'b1;
                    hdr_wdata          = hdr_mod;
                    out_valid_next     = 1'b1;
                    chunk_address_next = {blk_reg, off_reg};
                    status_next        = ST_OK;
                end
            end
            U_START:
            begin
                hdr_mod.nxt    = NONE_BLK;
                hdr_mod.prv    = NONE_BLK;
                hdr_mod.listed = 1'b0;
                hdr_next       = hdr_mod;
                hdr_we         = 1'b1;
                hdr_wdata      = hdr_mod;
            end
            U_HEAD:
            begin
                if (head_eff == {1'b0, blk_reg})
                begin
                    ch_we                        = 1'b1;
                    ch_wdata                     = blk_ok(nb_reg) ? nb_reg : NONE_BLK;
                    ch_valid_next[hdr_reg.cls]   = 1'b1;
                end
            end
            U_PN:
            begin
                hdr_waddr     = pb_reg[BLK_W-1:0];
                hdr_wmask     = '0;
                hdr_wmask.nxt = '1;
                hdr_wdata.nxt = nb_reg;
                hdr_we        = blk_ok(pb_reg);
            end
            U_NP:
            begin
                hdr_waddr     = nb_reg[BLK_W-1:0];
                hdr_wmask     = '0;
                hdr_wmask.prv = '1;
                hdr_wdata.prv = pb_reg;
                hdr_we        = blk_ok(nb_reg);
                if (ret_reg == RET_ALLOC_OK)
                begin
                    out_valid_next     = 1'b1;
                    chunk_address_next = {blk_reg, off_reg};
                    status_next        = ST_OK;
                end
                else if (ret_reg == RET_ALLOC_FAIL)
                begin
                    out_valid_next     = 1'b1;
                    chunk_address_next = '0;
                    status_next        = ST_NO_BLOCK;
                end
            end
            S_TOSPARE:
            begin
                hdr_wmask          = '0;
                hdr_wmask.nxt      = '1;
                hdr_wdata.nxt      = spare_reg;
                hdr_we             = 1'b1;
                spare_next         = {1'b0, blk_reg};
                out_valid_next     = 1'b1;
                chunk_address_next = '0;
                status_next        = ST_OK;
            end
            F_HDR:
            begin
                hdr_mod       = hdr_q;
                hdr_mod.used  = used_dec;
                hdr_mod.fhead = off_reg;
                hdr_next      = hdr_mod;
                lk_we         = 1'b1;
                lk_wdata      = hdr_q.fhead;
                ch_raddr      = hdr_q.cls;
                nb_next       = hdr_q.nxt;
                pb_next       = hdr_q.prv;
                ret_next      = RET_FREE_SPARE;
            end
            F_WB:
            begin
                hdr_we             = 1'b1;
                out_valid_next     = 1'b1;
                chunk_address_next = '0;
                status_next        = ST_OK;
            end
            F_PUSH:
            begin
                hdr_mod.nxt                = head_eff;
                hdr_mod.prv                = NONE_BLK;
                hdr_mod.listed             = 1'b1;
                hdr_next                   = hdr_mod;
                hdr_we                     = 1'b1;
                hdr_wdata                  = hdr_mod;
                ch_we                      = 1'b1;
                ch_valid_next[hdr_reg.cls] = 1'b1;
                nb_next                    = head_eff;
                if (!head_ok)
                begin
                    out_valid_next     = 1'b1;
                    chunk_address_next = '0;
                    status_next        = ST_OK;
                end
            end
            F_PUSH2:
            begin
                hdr_waddr          = nb_reg[BLK_W-1:0];
                hdr_wmask          = '0;
                hdr_wmask.prv      = '1;
                hdr_wdata.prv      = {1'b0, blk_reg};
                hdr_we             = 1'b1;
                out_valid_next     = 1'b1;
                chunk_address_next = '0;
                status_next        = ST_OK;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ret_reg          <= RET_ALLOC_OK;
            spare_reg        <= NONE_BLK;
            bump_reg         <= '0;
            blocks_avail_reg <= BID_W'(1024);
            ch_valid_reg     <= '0;
            head_vld_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            spare_reg     <= spare_next;
            bump_reg      <= bump_next;
            ch_valid_reg  <= ch_valid_next;
            head_vld_reg  <= ch_valid_reg[ch_raddr];
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
            begin
                blocks_avail_reg <= pwdata[BID_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg           <= blk_next;
        off_reg           <= off_next;
        cls_reg           <= cls_next;
        hdr_reg           <= hdr_next;
        nb_reg            <= nb_next;
        pb_reg            <= pb_next;
        chunk_address_reg <= chunk_address_next;
        status_reg        <= status_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        bump_reg <= NONE_BLK)
        else $error("bump count beyond block count");

    assert property (@(posedge clk) disable iff (!rst_n)
        spare_reg <= NONE_BLK)
        else $error("spare list head out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !out_valid_reg)
        else $error("result pending while a transaction is in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_OK && chunk_address_reg != '0)
            |-> ({1'b0, chunk_address_reg[ADDR_W-1:OFF_W]} < bump_reg))
        else $error("chunk handed out from a block never bumped");

endmodule

/* bench/size_class_slab_allocator_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_slab_allocator_unit_test
// Self-checking bench for the slab allocator. A directed table covers sizes at
// the edges, rejected frees and block reuse. Random phases under several block
// limits then mix allocations with frees of live chunks. Every result is
// compared with the expected answer of the table for typed directed rows and
// otherwise with the answer of a behavioral allocator kept in this bench.
// ----------------------------------------------------------------------------
module size_class_slab_allocator_unit_test;
    import scsa_pkg::*;

    localparam int STORE   = NUM_BLOCKS * BLOCK_BYTES;
    localparam int LIMIT   = 600000;
    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [1:0]        st;
    } chunk_result_t;

    typedef struct {
        logic              fn;
        logic [15:0]       size;
        logic [31:0]       addr;
        bit                typed;
        logic [ADDR_W-1:0] exp_addr;
        logic [1:0]        exp_st;
    } stim_row_t;

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 0;
    logic in_stall;
    logic func = FN_ALLOC;
    logic [15:0] request_size = '0;
    logic [31:0] free_address = '0;
    logic out_valid;
    logic out_stall = 0;
    logic [ADDR_W-1:0] chunk_address;
    logic [1:0] status;

    size_class_slab_allocator_unit DUT (.*);

    always #10 clk = ~clk;

    chunk_result_t pending[$];
    int unsigned   live_chunks[$];
    int            errors = 0;
    int            cycles = 0;
    bit            calm = 0;

    // Behavioral allocator state.
    int unsigned avail;
    int unsigned cls_head[NUM_CLASSES];
    int unsigned b_cls[NUM_BLOCKS];
    int unsigned b_next[NUM_BLOCKS];
    int unsigned b_prev[NUM_BLOCKS];
    int unsigned b_uninit[NUM_BLOCKS];
    int unsigned b_fhead[NUM_BLOCKS];
    int unsigned b_used[NUM_BLOCKS];
    bit          b_listed[NUM_BLOCKS];
    int unsigned link_mem[int unsigned];
    int unsigned spare_head;
    int unsigned bumped;

    function automatic int unsigned link_at(int unsigned idx);
        return link_mem.exists(idx) ? link_mem[idx] : 0;
    endfunction

    function automatic void list_push(int unsigned b);
        int unsigned c;
        c = b_cls[b];
        b_next[b] = cls_head[c];
        b_prev[b] = NUM_BLOCKS;
        if (cls_head[c] < NUM_BLOCKS)
            b_prev[cls_head[c]] = b;
        cls_head[c] = b;
        b_listed[b] = 1;
    endfunction

    function automatic void list_unlink(int unsigned b);
        int unsigned c, n, p;
        c = b_cls[b];
        n = b_next[b];
        p = b_prev[b];
        if (cls_head[c] == b)
            cls_head[c] = (n < NUM_BLOCKS) ? n : NUM_BLOCKS;
        if (p < NUM_BLOCKS)
            b_next[p] = n;
        if (n < NUM_BLOCKS)
            b_prev[n] = p;
        b_next[b] = NUM_BLOCKS;
        b_prev[b] = NUM_BLOCKS;
        b_listed[b] = 0;
    endfunction

    function automatic chunk_result_t alloc_chunk(int unsigned req);
        chunk_result_t r;
        int unsigned lim, sz, c, b, off;
        r.addr = '0;
        r.st = ST_OK;
        lim = (avail < NUM_BLOCKS) ? avail : NUM_BLOCKS;
        if (req == 0 || req > MAX_CHUNK) begin
            r.st = ST_BAD_SIZE;
            return r;
        end
        sz = (req + SIZE_STEP - 1) / SIZE_STEP * SIZE_STEP;
        if (HEADER_BYTES + sz > BLOCK_BYTES) begin
            r.st = ST_BAD_SIZE;
            return r;
        end
        c = sz / SIZE_STEP;
        b = cls_head[c];
        if (b >= NUM_BLOCKS) begin
            if (spare_head < NUM_BLOCKS) begin
                b = spare_head;
                spare_head = (b_next[b] < NUM_BLOCKS) ? b_next[b] : NUM_BLOCKS;
            end else if (bumped < lim) begin
                b = bumped;
                bumped++;
            end else begin
                r.st = ST_NO_BLOCK;
                return r;
            end
            b_cls[b] = c;
            b_uninit[b] = HEADER_BYTES;
            b_fhead[b] = 0;
            b_used[b] = 0;
            list_push(b);
        end
        sz = b_cls[b] * SIZE_STEP;
        off = b_uninit[b];
        if (off != 0 && off < BLOCK_BYTES) begin
            b_uninit[b] = (off + 2 * sz > BLOCK_BYTES) ? 0 : off + sz;
        end else begin
            b_uninit[b] = 0;
            off = b_fhead[b];
            if (off == 0 || off >= BLOCK_BYTES) begin
                b_fhead[b] = 0;
                list_unlink(b);
                r.st = ST_NO_BLOCK;
                return r;
            end
            b_fhead[b] = link_at((b * BLOCK_BYTES + off) / SIZE_STEP);
            if (b_fhead[b] >= BLOCK_BYTES)
                b_fhead[b] = 0;
        end
        b_used[b]++;
        if (b_uninit[b] == 0 && b_fhead[b] == 0)
            list_unlink(b);
        r.addr = ADDR_W'(b * BLOCK_BYTES + off);
        return r;
    endfunction

    function automatic chunk_result_t free_chunk(int unsigned a);
        chunk_result_t r;
        int unsigned b, off;
        r.addr = '0;
        r.st = ST_OK;
        b = a / BLOCK_BYTES;
        off = a % BLOCK_BYTES;
        if (a >= STORE || b >= bumped || off < HEADER_BYTES) begin
            r.st = ST_BAD_ADDR;
            return r;
        end
        if (b_used[b] > 0)
            b_used[b]--;
        link_mem[(b * BLOCK_BYTES + off) / SIZE_STEP] = b_fhead[b];
        b_fhead[b] = off;
        if (!b_listed[b]) begin
            list_push(b);
        end else if (b_used[b] == 0) begin
            list_unlink(b);
            b_next[b] = spare_head;
            spare_head = b;
        end
        return r;
    endfunction

    function automatic int unsigned draw_wait();
        return (calm || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 14);
    endfunction

    task automatic send(input stim_row_t row);
        chunk_result_t r;
        int unsigned gap, i;
        if (row.fn == FN_ALLOC) begin
            r = alloc_chunk(row.size);
            if (r.st == ST_OK)
                live_chunks.push_back(r.addr);
        end else begin
            r = free_chunk(row.addr);
            if (r.st == ST_OK)
                for (i = 0; i < live_chunks.size(); i++)
                    if (live_chunks[i] == row.addr) begin
                        live_chunks.delete(i);
                        break;
                    end
        end
        if (row.typed) begin
            r.addr = row.exp_addr;
            r.st = row.exp_st;
        end
        pending.push_back(r);
        gap = draw_wait();
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        func <= row.fn;
        request_size <= row.size;
        free_address <= row.addr;
        forever begin
            @(posedge clk);
            if (in_valid && !in_stall)
                break;
        end
    endtask

    task automatic write_blocks_available(input int unsigned value);
        in_valid <= 0;
        while (pending.size() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= 3'(4 * REG_BLOCKS_AVAIL);
        pwdata <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        avail = value & 32'h7FF;
    endtask

    function automatic stim_row_t random_row(int unsigned alloc_pct);
        stim_row_t row;
        int unsigned r, b;
        row.typed = 0;
        row.exp_addr = '0;
        row.exp_st = ST_OK;
        row.fn = FN_ALLOC;
        row.size = 16'($urandom_range(1, MAX_CHUNK));
        row.addr = $urandom;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            row.size = ($urandom_range(0, 3) == 0) ? 16'd0
                                                    : 16'($urandom_range(257, 65535));
        end else if (r < 12) begin
            row.fn = FN_FREE;
            case ($urandom_range(0, 2))
                0: row.addr = $urandom | 32'(STORE);
                1: begin
                    if (bumped < NUM_BLOCKS) begin
                        b = $urandom_range(bumped, NUM_BLOCKS - 1);
                        row.addr = b * BLOCK_BYTES + $urandom_range(0, BLOCK_BYTES - 1);
                    end else begin
                        row.addr = $urandom | 32'(STORE);
                    end
                end
                default: begin
                    if (bumped > 0)
                        row.addr = $urandom_range(0, bumped - 1) * BLOCK_BYTES
                                   + $urandom_range(0, HEADER_BYTES - 1);
                    else
                        row.addr = $urandom_range(0, HEADER_BYTES - 1);
                end
            endcase
        end else if (live_chunks.size() > 0 && $urandom_range(0, 99) >= alloc_pct) begin
            row.fn = FN_FREE;
            row.addr = live_chunks[$urandom_range(0, live_chunks.size() - 1)];
        end else if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 3))
                0: row.size = 16'd8;
                1: row.size = 16'd256;
                2: row.size = 16'd200;
                default: row.size = 16'd33;
            endcase
        end
        if (row.fn == FN_ALLOC)
            row.addr = $urandom;
        return row;
    endfunction

    stim_row_t directed[] = '{
        '{FN_ALLOC, 16'd8,     32'd0,          1, 22'd56,   ST_OK},
        '{FN_ALLOC, 16'd256,   32'd0,          1, 22'd4152, ST_OK},
        '{FN_ALLOC, 16'd0,     32'd0,          1, 22'd0,    ST_BAD_SIZE},
        '{FN_ALLOC, 16'd257,   32'd0,          1, 22'd0,    ST_BAD_SIZE},
        '{FN_ALLOC, 16'hFFFF,  32'hFFFF_FFFF,  1, 22'd0,    ST_BAD_SIZE},
        '{FN_FREE,  16'hFFFF,  32'hFFFF_FFFF,  1, 22'd0,    ST_BAD_ADDR},
        '{FN_FREE,  16'd0,     32'h0040_0000,  1, 22'd0,    ST_BAD_ADDR},
        '{FN_FREE,  16'd0,     32'd20580,      1, 22'd0,    ST_BAD_ADDR},
        '{FN_FREE,  16'd0,     32'd4104,       1, 22'd0,    ST_BAD_ADDR},
        '{FN_FREE,  16'd0,     32'd55,         1, 22'd0,    ST_BAD_ADDR},
        '{FN_FREE,  16'd0,     32'd56,         1, 22'd0,    ST_OK},
        '{FN_ALLOC, 16'd1,     32'd0,          1, 22'd56,   ST_OK},
        '{FN_FREE,  16'd0,     32'd4152,       1, 22'd0,    ST_OK},
        '{FN_ALLOC, 16'd255,   32'd0,          0, 22'd0,    ST_OK},
        '{FN_ALLOC, 16'd7,     32'd0,          0, 22'd0,    ST_OK},
        '{FN_ALLOC, 16'd24,    32'd0,          0, 22'd0,    ST_OK},
        '{FN_ALLOC, 16'd100,   32'd0,          0, 22'd0,    ST_OK},
        '{FN_FREE,  16'd0,     32'd64,         0, 22'd0,    ST_OK},
        '{FN_ALLOC, 16'd8,     32'd0,          0, 22'd0,    ST_OK},
        '{FN_ALLOC, 16'd249,   32'd0,          0, 22'd0,    ST_OK}
    };

    int unsigned phase_limit[6] = '{1, 3, 1, 1024, 2, 700};
    int unsigned phase_items[6] = '{30, 250, 120, 400, 200, 330};
    int unsigned phase_alloc[6] = '{90, 70, 60, 55, 65, 50};

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk) begin
        chunk_result_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (pending.size() == 0) begin
                $display("%0t: unexpected transaction, actual address %0d status %0d",
                         $time, chunk_address, status);
                errors++;
            end else begin
                e = pending.pop_front();
                if (chunk_address !== e.addr) begin
                    $display("%0t: chunk_address expected %0d actual %0d",
                             $time, e.addr, chunk_address);
                    errors++;
                end
                if (status !== e.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                    errors++;
                end
            end
        end
    end

    initial begin
        int unsigned k;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            k = draw_wait();
            if (k > 0) begin
                out_stall <= 1;
                repeat (k) @(posedge clk);
            end
            out_stall <= 0;
            forever begin
                @(posedge clk);
                if (out_valid && !out_stall)
                    break;
            end
        end
    end

    initial begin
        int unsigned p, n, i;
        avail = 1024;
        for (i = 0; i < NUM_CLASSES; i++)
            cls_head[i] = NUM_BLOCKS;
        spare_head = NUM_BLOCKS;
        bumped = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        foreach (directed[i])
            send(directed[i]);
        for (p = 0; p < 6; p++) begin
            write_blocks_available(phase_limit[p]);
            for (n = 0; n < phase_items[p]; n++) begin
                if ($urandom_range(0, 49) == 0)
                    calm = ~calm;
                if (p == 3 && n == 200) begin
                    in_valid <= 0;
                    while (pending.size() > 0)
                        @(posedge clk);
                end
                send(random_row(phase_alloc[p]));
            end
            in_valid <= 0;
        end
        write_blocks_available(1024);
        for (n = 0; n < 20; n++)
            send(random_row(50));
        in_valid <= 0;
        while (pending.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* size_class_slab_allocator_unit.f */
rtl/core/scsa_pkg.sv
rtl/core/scsa_ram.sv
rtl/core/size_class_slab_allocator_unit.sv
bench/size_class_slab_allocator_unit_test.sv
